>>> design/chtms_pkg.sv
// ----------------------------------------------------------------------------
// chtms_pkg: shared types and constants of the chained hash table
// Sizes, node word layout, request codes and the reciprocal constants of the
// mid-square hash.
// ----------------------------------------------------------------------------
package chtms_pkg;

	localparam int BUCKETS    = 10;
	localparam int POOL_NODES = 64;

	localparam int KEY_W    = 16;
	localparam int LINK_W   = 7;
	localparam int STATUS_W = 2;
	localparam int BUCKET_W = 4;
	localparam int BKT_W    = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam int NODE_W   = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;
	localparam int STEP_W   = $clog2(POOL_NODES + 1);

	localparam logic [LINK_W-1:0] NIL_LINK = LINK_W'(127);

	// x / 100 as a multiply by a rounded-up reciprocal, exact for x < 2^17
	localparam int DIV100_SHIFT = 24;
	localparam int DIV100_MUL   = (1 << DIV100_SHIFT) / 100 + 1;

	// x / BUCKETS for x < 100
	localparam int BKT_SHIFT = 16;
	localparam int BKT_MUL   = (1 << BKT_SHIFT) / BUCKETS + 1;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_DELETE = 1'b1
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_DONE = 2'd0,
		STAT_MISS = 2'd1,
		STAT_FULL = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_HASH,
		S_HEAD,
		S_WALK,
		S_RET,
		S_FIN
	} state_t;

	typedef struct packed {
		logic [KEY_W-1:0]  key;
		logic [LINK_W-1:0] link;
	} node_t;

	typedef struct packed {
		logic              head_re;
		logic [BKT_W-1:0]  head_raddr;
		logic              head_we;
		logic [BKT_W-1:0]  head_waddr;
		logic [LINK_W-1:0] head_wdata;
		logic              node_re;
		logic [NODE_W-1:0] node_raddr;
		logic              node_we;
		logic [NODE_W-1:0] node_waddr;
		node_t             node_wdata;
	} mem_req_t;

	typedef struct packed {
		logic             valid;
		status_t          status;
		logic [BKT_W-1:0] bucket;
	} res_t;

	function automatic logic [10:0] div100(input logic [16:0] x);
		logic [34:0] p;
		p = 35'(x) * 35'(DIV100_MUL);
		return 11'(p >> DIV100_SHIFT);
	endfunction

	function automatic logic is_node(input logic [LINK_W-1:0] l);
		return l < LINK_W'(POOL_NODES);
	endfunction

	function automatic logic [LINK_W-1:0] rst_link(input logic [NODE_W-1:0] idx);
		logic [LINK_W-1:0] nxt;
		nxt = LINK_W'(idx) + LINK_W'(1);
		return (nxt < LINK_W'(POOL_NODES)) ? nxt : NIL_LINK;
	endfunction

endpackage

>>> design/chtms_req_if.sv
// ----------------------------------------------------------------------------
// chtms_req_if: request channel
// Valid/ready channel carrying one insert or delete request.
// ----------------------------------------------------------------------------
interface chtms_req_if;
	import chtms_pkg::*;

	logic             valid;
	logic             ready;
	logic             op;
	logic [KEY_W-1:0] key;

	modport source (output valid, output op, output key, input ready);
	modport sink (input valid, input op, input key, output ready);
endinterface

>>> design/chtms_rsp_if.sv
// ----------------------------------------------------------------------------
// chtms_rsp_if: response channel
// Valid/ready channel carrying the status and bucket of one request.
// ----------------------------------------------------------------------------
interface chtms_rsp_if;
	import chtms_pkg::*;

	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [BUCKET_W-1:0] bucket;

	modport source (output valid, output status, output bucket, input ready);
	modport sink (input valid, input status, input bucket, output ready);
endinterface

>>> design/chtms_hash.sv
// ----------------------------------------------------------------------------
// chtms_hash: mid-square hash pipeline
// With key = 100a + b the middle digits of key^2 are (2ab + b^2/100) mod 100;
// nine stages, the last two reducing modulo the bucket count.
// ----------------------------------------------------------------------------
module chtms_hash (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [chtms_pkg::KEY_W-1:0] key,
	output logic                       done,
	output logic [chtms_pkg::BKT_W-1:0] bucket
);
	import chtms_pkg::*;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;

	logic [KEY_W-1:0] key_s1, key_s2;
	logic [9:0]       a_s2, a_s3;
	logic [6:0]       b_s3;
	logic [16:0]      p_s4;
	logic [13:0]      bsq_s4;
	logic [16:0]      t_s5, t_s6;
	logic [10:0]      tq_s6;
	logic [6:0]       mid_s7, mid_s8;
	logic [6:0]       mq_s8;
	logic [BKT_W-1:0] bucket_s9;
	logic [23:0]      mq_prod;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
			v_s9 <= v_s8;
		end
	end

	assign mq_prod = 24'(mid_s7) * 24'(BKT_MUL);

	always_ff @(posedge clk) begin
		key_s1    <= key;
		key_s2    <= key_s1;
		a_s2      <= 10'(div100(17'(key_s1)));
		a_s3      <= a_s2;
		b_s3      <= 7'(key_s2 - 16'(16'(a_s2) * 16'd100));
		p_s4      <= 17'(17'({a_s3, 1'b0}) * 17'(b_s3));
		bsq_s4    <= 14'(14'(b_s3) * 14'(b_s3));
		t_s5      <= p_s4 + 17'(div100(17'(bsq_s4)));
		t_s6      <= t_s5;
		tq_s6     <= div100(t_s5);
		mid_s7    <= 7'(t_s6 - 17'(17'(tq_s6) * 17'd100));
		mid_s8    <= mid_s7;
		mq_s8     <= 7'(mq_prod >> BKT_SHIFT);
		bucket_s9 <= BKT_W'(16'(mid_s8) - 16'(16'(mq_s8) * 16'(BUCKETS)));
	end

	assign done   = v_s9;
	assign bucket = bucket_s9;

endmodule

>>> design/chtms_store.sv
// ----------------------------------------------------------------------------
// chtms_store: bucket head and node memories
// Two synchronous memories with one registered read port each; per-entry
// valid bits make never-written entries read as their reset contents.
// ----------------------------------------------------------------------------
module chtms_store (
	input  logic                         clk,
	input  logic                         arst_n,
	input  chtms_pkg::mem_req_t          mreq,
	output logic [chtms_pkg::LINK_W-1:0] head_rdata,
	output chtms_pkg::node_t             node_rdata
);
	import chtms_pkg::*;

	logic [LINK_W-1:0] head_mem [BUCKETS];
	node_t             node_mem [POOL_NODES];

	logic [BUCKETS-1:0]    head_vld_q;
	logic [POOL_NODES-1:0] node_vld_q;

	logic [LINK_W-1:0] head_q;
	logic              head_hit_q;
	node_t             node_q;
	logic              node_hit_q;
	logic [NODE_W-1:0] node_addr_q;

	always_ff @(posedge clk) begin
		if (mreq.head_we) begin
			head_mem[mreq.head_waddr] <= mreq.head_wdata;
		end
		if (mreq.head_re) begin
			head_q <= head_mem[mreq.head_raddr];
		end
		if (mreq.node_we) begin
			node_mem[mreq.node_waddr] <= mreq.node_wdata;
		end
		if (mreq.node_re) begin
			node_q      <= node_mem[mreq.node_raddr];
			node_addr_q <= mreq.node_raddr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_vld_q <= '0;
			node_vld_q <= '0;
			head_hit_q <= 1'b0;
			node_hit_q <= 1'b0;
		end else begin
			if (mreq.head_we) begin
				head_vld_q[mreq.head_waddr] <= 1'b1;
			end
			if (mreq.node_we) begin
				node_vld_q[mreq.node_waddr] <= 1'b1;
			end
			if (mreq.head_re) begin
				head_hit_q <= head_vld_q[mreq.head_raddr];
			end
			if (mreq.node_re) begin
				node_hit_q <= node_vld_q[mreq.node_raddr];
			end
		end
	end

	assign head_rdata = head_hit_q ? head_q : NIL_LINK;

	always_comb begin
		if (node_hit_q) begin
			node_rdata = node_q;
		end else begin
			node_rdata.key  = '0;
			node_rdata.link = rst_link(node_addr_q);
		end
	end

endmodule

>>> design/chtms_ctrl.sv
// ----------------------------------------------------------------------------
// chtms_ctrl: request sequencer
// Waits for the hash, reads the bucket head, then pushes a node on insert or
// walks the chain one node per cycle and unlinks the match on delete.
// ----------------------------------------------------------------------------
module chtms_ctrl (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	input  chtms_pkg::op_t               req_op,
	input  logic [chtms_pkg::KEY_W-1:0]  req_key,
	output logic                         req_ready,
	output logic                         hash_start,
	input  logic                         hash_done,
	input  logic [chtms_pkg::BKT_W-1:0]  hash_bucket,
	output chtms_pkg::mem_req_t          mreq,
	input  logic [chtms_pkg::LINK_W-1:0] head_rdata,
	input  chtms_pkg::node_t             node_rdata,
	output chtms_pkg::res_t              res,
	input  logic                         res_ready
);
	import chtms_pkg::*;

	state_t state_q, state_d;

	op_t               op_q;
	logic [KEY_W-1:0]  key_q;
	logic [BKT_W-1:0]  bucket_q;
	logic [LINK_W-1:0] free_q;
	logic [LINK_W-1:0] cur_q;
	logic [LINK_W-1:0] prev_q;
	logic [KEY_W-1:0]  prev_key_q;
	logic [KEY_W-1:0]  cur_key_q;
	logic [STEP_W-1:0] steps_q;
	status_t           status_q;

	logic              hit;
	logic [STEP_W-1:0] next_steps;
	logic              go_on;

	assign hit        = (node_rdata.key == key_q);
	assign next_steps = steps_q + STEP_W'(1);
	assign go_on      = is_node(node_rdata.link) && (next_steps < STEP_W'(POOL_NODES));

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					state_d = S_HASH;
				end
			end
			S_HASH: begin
				if (hash_done) begin
					state_d = S_HEAD;
				end
			end
			S_HEAD: begin
				if (op_q == OP_DELETE && is_node(head_rdata)) begin
					state_d = S_WALK;
				end else begin
					state_d = S_FIN;
				end
			end
			S_WALK: begin
				priority if (hit) begin
					state_d = S_RET;
				end else if (go_on) begin
					state_d = S_WALK;
				end else begin
					state_d = S_FIN;
				end
			end
			S_RET: begin
				state_d = S_FIN;
			end
			S_FIN: begin
				if (res_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		req_ready  = 1'b0;
		hash_start = 1'b0;
		mreq       = '0;
		res.valid  = 1'b0;
		res.status = status_q;
		res.bucket = bucket_q;
		unique case (state_q)
			S_IDLE: begin
				req_ready  = 1'b1;
				hash_start = req_valid;
			end
			S_HASH: begin
				if (hash_done) begin
					mreq.head_re    = 1'b1;
					mreq.head_raddr = hash_bucket;
					mreq.node_re    = is_node(free_q);
					mreq.node_raddr = NODE_W'(free_q);
				end
			end
			S_HEAD: begin
				if (op_q == OP_INSERT) begin
					if (is_node(free_q)) begin
						mreq.node_we         = 1'b1;
						mreq.node_waddr      = NODE_W'(free_q);
						mreq.node_wdata.key  = key_q;
						mreq.node_wdata.link = head_rdata;
						mreq.head_we         = 1'b1;
						mreq.head_waddr      = bucket_q;
						mreq.head_wdata      = free_q;
					end
				end else if (is_node(head_rdata)) begin
					mreq.node_re    = 1'b1;
					mreq.node_raddr = NODE_W'(head_rdata);
				end
			end
			S_WALK: begin
				priority if (hit) begin
					if (is_node(prev_q)) begin
						mreq.node_we         = 1'b1;
						mreq.node_waddr      = NODE_W'(prev_q);
						mreq.node_wdata.key  = prev_key_q;
						mreq.node_wdata.link = node_rdata.link;
					end else begin
						mreq.head_we    = 1'b1;
						mreq.head_waddr = bucket_q;
						mreq.head_wdata = node_rdata.link;
					end
				end else if (go_on) begin
					mreq.node_re    = 1'b1;
					mreq.node_raddr = NODE_W'(node_rdata.link);
				end
			end
			S_RET: begin
				mreq.node_we         = 1'b1;
				mreq.node_waddr      = NODE_W'(cur_q);
				mreq.node_wdata.key  = cur_key_q;
				mreq.node_wdata.link = free_q;
			end
			S_FIN: begin
				res.valid = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			free_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_HEAD && op_q == OP_INSERT && is_node(free_q)) begin
				free_q <= node_rdata.link;
			end
			if (state_q == S_RET) begin
				free_q <= cur_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					op_q  <= req_op;
					key_q <= req_key;
				end
			end
			S_HASH: begin
				if (hash_done) begin
					bucket_q <= hash_bucket;
				end
			end
			S_HEAD: begin
				if (op_q == OP_INSERT) begin
					status_q <= is_node(free_q) ? STAT_DONE : STAT_FULL;
				end else begin
					status_q <= is_node(head_rdata) ? STAT_DONE : STAT_MISS;
				end
				cur_q   <= head_rdata;
				prev_q  <= NIL_LINK;
				steps_q <= '0;
			end
			S_WALK: begin
				if (hit) begin
					cur_key_q <= node_rdata.key;
				end else begin
					prev_q     <= cur_q;
					prev_key_q <= node_rdata.key;
					cur_q      <= node_rdata.link;
					steps_q    <= next_steps;
					if (!go_on) begin
						status_q <= STAT_MISS;
					end
				end
			end
			default: begin
			end
		endcase
	end

endmodule

>>> design/chained_hash_table_mid_square.sv
// ----------------------------------------------------------------------------
// chained_hash_table_mid_square: hash table with separate chaining
// Inserts and deletes 16-bit keys; buckets from the mid-square hash, nodes
// from a bounded free pool, one response per request.
//
//   port   dir   fields          meaning
//   req    in    op, key         insert or delete one key
//   rsp    out   status, bucket  outcome and bucket of the request
//
// Each request runs the nine-stage hash pipeline and reads the bucket head;
// an insert then pushes a node, and a delete walks the chain one node per
// cycle through the node memory and frees the node that holds the key.
// One request is in flight at a time; the next one is accepted while a
// response still waits in the output register. Reset empties every bucket
// and chains all nodes into the free pool at once.
// ----------------------------------------------------------------------------
module chained_hash_table_mid_square (
	input logic        clk,
	input logic        arst_n,
	chtms_req_if.sink  req,
	chtms_rsp_if.source rsp
);
	import chtms_pkg::*;

	logic              hash_start;
	logic              hash_done;
	logic [BKT_W-1:0]  hash_bucket;
	mem_req_t          mreq;
	logic [LINK_W-1:0] head_rdata;
	node_t             node_rdata;
	res_t              res;
	logic              res_ready;

	logic              rsp_vld_q;
	status_t           rsp_status_q;
	logic [BKT_W-1:0]  rsp_bucket_q;

	chtms_hash u_hash (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (hash_start),
		.key    (req.key),
		.done   (hash_done),
		.bucket (hash_bucket)
	);

	chtms_store u_store (
		.clk        (clk),
		.arst_n     (arst_n),
		.mreq       (mreq),
		.head_rdata (head_rdata),
		.node_rdata (node_rdata)
	);

	chtms_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req.valid),
		.req_op      (op_t'(req.op)),
		.req_key     (req.key),
		.req_ready   (req.ready),
		.hash_start  (hash_start),
		.hash_done   (hash_done),
		.hash_bucket (hash_bucket),
		.mreq        (mreq),
		.head_rdata  (head_rdata),
		.node_rdata  (node_rdata),
		.res         (res),
		.res_ready   (res_ready)
	);

	assign res_ready = !rsp_vld_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_vld_q <= 1'b0;
		end else if (res_ready) begin
			rsp_vld_q <= res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid && res_ready) begin
			rsp_status_q <= res.status;
			rsp_bucket_q <= res.bucket;
		end
	end

	assign rsp.valid  = rsp_vld_q;
	assign rsp.status = STATUS_W'(rsp_status_q);
	assign rsp.bucket = BUCKET_W'(rsp_bucket_q);

	a_node_port_apart: assert property (@(posedge clk) disable iff (!arst_n)
		mreq.node_we && mreq.node_re |-> mreq.node_waddr != mreq.node_raddr)
		else $error("node memory read and write collide");

	a_head_port_apart: assert property (@(posedge clk) disable iff (!arst_n)
		mreq.head_we && mreq.head_re |-> mreq.head_waddr != mreq.head_raddr)
		else $error("bucket head memory read and write collide");

	a_accept_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |-> !res.valid && !mreq.node_we && !mreq.head_we)
		else $error("request accepted while previous one still active");

	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res_ready |=> rsp_vld_q && $past(res.status) == rsp_status_q)
		else $error("finished result not loaded into output register");

endmodule

>>> dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: request/response check of the chained hash table
// Sends insert and delete requests with bursty timing while the response side
// stalls at random. A local copy of the buckets, node pool and free list
// works out the status and bucket of every accepted request, and the outcome
// is compared in order with each response that comes back.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import chtms_pkg::*;

	localparam int MID_DIV = 100;

	typedef struct {
		status_t          status;
		logic [BUCKET_W-1:0] bucket;
	} outcome_t;

	logic clk;
	logic arst_n;

	chtms_req_if req_ch ();
	chtms_rsp_if rsp_ch ();

	chained_hash_table_mid_square u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// local copy of the table
	logic [LINK_W-1:0] chain_head [BUCKETS];
	logic [KEY_W-1:0]  slot_key [POOL_NODES];
	logic [LINK_W-1:0] slot_next [POOL_NODES];
	logic [LINK_W-1:0] free_slot;
	logic [KEY_W-1:0]  live_keys [$];

	outcome_t pending_rsp [$];
	int       mismatches = 0;
	int       burst_left = 0;

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#10ms;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	function automatic logic [BUCKET_W-1:0] mid_square_bucket(input logic [KEY_W-1:0] key);
		logic [31:0] sq;
		sq = 32'(key) * 32'(key);
		return BUCKET_W'(((sq / MID_DIV) % MID_DIV) % BUCKETS);
	endfunction

	function automatic void clear_table();
		for (int i = 0; i < BUCKETS; i++) chain_head[i] = NIL_LINK;
		for (int i = 0; i < POOL_NODES; i++) begin
			slot_key[i]  = '0;
			slot_next[i] = (i + 1 < POOL_NODES) ? LINK_W'(i + 1) : NIL_LINK;
		end
		free_slot = '0;
		live_keys.delete();
	endfunction

	function automatic outcome_t apply_request(input op_t op, input logic [KEY_W-1:0] key);
		outcome_t          r;
		logic [LINK_W-1:0] slot;
		logic [LINK_W-1:0] cur;
		logic [LINK_W-1:0] prev;
		int                steps;
		logic              found;
		r.bucket = mid_square_bucket(key);
		r.status = STAT_DONE;
		if (op == OP_INSERT) begin
			slot = free_slot;
			if (slot >= POOL_NODES) begin
				r.status = STAT_FULL;
			end else begin
				free_slot           = slot_next[slot];
				slot_key[slot]      = key;
				slot_next[slot]     = chain_head[r.bucket];
				chain_head[r.bucket] = slot;
				live_keys.push_back(key);
			end
		end else begin
			cur   = chain_head[r.bucket];
			prev  = NIL_LINK;
			steps = 0;
			found = 1'b0;
			while (cur < POOL_NODES && steps < POOL_NODES && !found) begin
				if (slot_key[cur] == key) begin
					found = 1'b1;
				end else begin
					prev = cur;
					cur  = slot_next[cur];
					steps++;
				end
			end
			if (!found) begin
				r.status = STAT_MISS;
			end else begin
				if (prev < POOL_NODES) slot_next[prev] = slot_next[cur];
				else chain_head[r.bucket] = slot_next[cur];
				slot_next[cur] = free_slot;
				free_slot      = cur;
				for (int i = 0; i < live_keys.size(); i++) begin
					if (live_keys[i] == key) begin
						live_keys.delete(i);
						break;
					end
				end
			end
		end
		return r;
	endfunction

	task automatic send_request(input op_t op, input logic [KEY_W-1:0] key);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
			if (gap > 0) begin
				req_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		req_ch.valid <= 1'b1;
		req_ch.op    <= op;
		req_ch.key   <= key;
		do @(posedge clk); while (!req_ch.ready);
		pending_rsp.push_back(apply_request(op, key));
	endtask

	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		burst_left = 0;
		while (pending_rsp.size() != 0) @(posedge clk);
	endtask

	function automatic logic [KEY_W-1:0] random_key();
		unique case ($urandom_range(0, 9))
			0:       return '0;
			1:       return '1;
			2, 3:    return KEY_W'($urandom_range(0, 15));
			default: return KEY_W'($urandom_range(0, 65535));
		endcase
	endfunction

	function automatic logic [KEY_W-1:0] delete_key();
		if (live_keys.size() != 0 && $urandom_range(0, 9) < 7)
			return live_keys[$urandom_range(0, live_keys.size() - 1)];
		return random_key();
	endfunction

	// response side: stall pattern and in-order compare
	int       stall_cycles = 0;
	int       stall_mode   = 0;
	outcome_t want;

	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_rsp.size() == 0) begin
				$error("response with no request outstanding: status %0d bucket %0d",
					rsp_ch.status, rsp_ch.bucket);
				mismatches++;
			end else begin
				want = pending_rsp.pop_front();
				if (rsp_ch.status !== want.status) begin
					$error("status: expected %0d, actual %0d", want.status, rsp_ch.status);
					mismatches++;
				end
				if (rsp_ch.bucket !== want.bucket) begin
					$error("bucket: expected %0d, actual %0d", want.bucket, rsp_ch.bucket);
					mismatches++;
				end
			end
		end
		if (stall_cycles == 0) begin
			stall_cycles = $urandom_range(20, 120);
			stall_mode   = $urandom_range(0, 3);
		end
		stall_cycles--;
		unique case (stall_mode)
			0:       rsp_ch.ready <= 1'b1;
			1:       rsp_ch.ready <= ($urandom_range(0, 99) < 70);
			2:       rsp_ch.ready <= ($urandom_range(0, 99) < 25);
			default: rsp_ch.ready <= (stall_cycles % 5 != 0);
		endcase
	end

	task automatic test_directed();
		logic [KEY_W-1:0] mates [$];
		logic [BUCKET_W-1:0] b0;
		b0 = mid_square_bucket(KEY_W'(1000));
		for (int k = 1000; mates.size() < 4; k++)
			if (mid_square_bucket(KEY_W'(k)) == b0) mates.push_back(KEY_W'(k));
		send_request(OP_DELETE, '0);
		send_request(OP_INSERT, '0);
		send_request(OP_INSERT, '1);
		send_request(OP_INSERT, '0);
		send_request(OP_DELETE, '0);
		send_request(OP_DELETE, '0);
		send_request(OP_DELETE, '0);
		send_request(OP_INSERT, mates[0]);
		send_request(OP_INSERT, mates[1]);
		send_request(OP_INSERT, mates[2]);
		send_request(OP_DELETE, mates[3]);
		send_request(OP_DELETE, mates[1]);
		send_request(OP_DELETE, mates[0]);
		send_request(OP_INSERT, mates[1]);
		send_request(OP_DELETE, mates[2]);
		send_request(OP_DELETE, mates[1]);
		send_request(OP_DELETE, '1);
		send_request(OP_INSERT, KEY_W'(16'h8000));
		send_request(OP_INSERT, KEY_W'(16'h7fff));
		send_request(OP_INSERT, KEY_W'(16'h5555));
		send_request(OP_INSERT, KEY_W'(16'haaaa));
		send_request(OP_DELETE, KEY_W'(16'h5555));
	endtask

	task automatic test_pool_full();
		int extra;
		extra = 0;
		while (extra < 3) begin
			if (free_slot >= POOL_NODES) extra++;
			send_request(OP_INSERT, random_key());
		end
		wait_drained();
		while (live_keys.size() != 0)
			send_request(OP_DELETE, live_keys[$urandom_range(0, live_keys.size() - 1)]);
		send_request(OP_DELETE, random_key());
	endtask

	task automatic test_random_mix();
		int insert_pct;
		for (int phase = 0; phase < 10; phase++) begin
			unique case (phase % 4)
				0:       insert_pct = 80;
				1:       insert_pct = 50;
				2:       insert_pct = 95;
				default: insert_pct = 20;
			endcase
			for (int i = 0; i < 55; i++) begin
				if ($urandom_range(0, 99) < insert_pct) send_request(OP_INSERT, random_key());
				else send_request(OP_DELETE, delete_key());
			end
		end
	endtask

	initial begin
		arst_n       <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.op    <= OP_INSERT;
		req_ch.key   <= '0;
		clear_table();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_pool_full();
		test_random_mix();
		wait_drained();
		repeat (120) @(posedge clk);
		if (mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

>>> chained_hash_table_mid_square.f
design/chtms_pkg.sv
design/chtms_req_if.sv
design/chtms_rsp_if.sv
design/chtms_hash.sv
design/chtms_store.sv
design/chtms_ctrl.sv
design/chained_hash_table_mid_square.sv
dv/testbench.sv
